// ===== src/via_pkg.sv =====
// Shared types and constants for the view id allocator.
// Holds the transaction payloads, request codes and controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package via_pkg;

  localparam logic [1:0] ReqAlloc   = 2'd0;
  localparam logic [1:0] ReqRelease = 2'd1;
  localparam logic [1:0] ReqReset   = 2'd2;

  localparam int unsigned FirstId = 1;
  localparam logic [15:0] SatMax  = 16'hFFFF;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] release_id;
  } via_req_t;

  typedef struct packed {
    logic [7:0]  granted_id;
    logic        used_fallback;
    logic [15:0] live_now;
    logic [15:0] live_peak;
    logic [15:0] exhaust_total;
    logic [6:0]  free_entries;
  } via_rsp_t;

  typedef struct packed {
    logic exec;
    logic load_pop;
  } via_cmd_t;

  typedef struct packed {
    logic pop_hit;
  } via_sts_t;

endpackage

`default_nettype wire

// ===== src/via_ctrl.sv =====
// Controller for the view id allocator: sequences accept, stack read and response.
// Depends on via_pkg.
`timescale 1ns / 1ps
`default_nettype none

module via_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire via_pkg::via_sts_t sts_i,
  output via_pkg::via_cmd_t   cmd_o
);
  import via_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StPop,
    StResp
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  assign cmd_o.exec     = in_valid_i & in_ready_q;
  assign cmd_o.load_pop = (state_q == StPop);
  assign in_ready_o     = in_ready_q;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            in_ready_q <= 1'b0;
            if (sts_i.pop_hit) begin
              state_q <= StPop;
            end else begin
              state_q     <= StResp;
              out_valid_q <= 1'b1;
            end
          end
        end
        StPop: begin
          state_q     <= StResp;
          out_valid_q <= 1'b1;
        end
        StResp: begin
          if (out_ready_i) begin
            state_q     <= StIdle;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= StIdle;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/via_dpath.sv =====
// Datapath for the view id allocator: free stack memory, bump pointer, counters.
// Result register holds the response. Depends on via_pkg.
`timescale 1ns / 1ps
`default_nettype none

module via_dpath #(
  parameter int unsigned MAX_ID     = 255,
  parameter int unsigned FREE_DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire via_pkg::via_req_t req_i,
  input  wire via_pkg::via_cmd_t cmd_i,
  output via_pkg::via_sts_t      sts_o,
  output via_pkg::via_rsp_t      rsp_o
);
  import via_pkg::*;

  localparam int unsigned AW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FREE_DEPTH + 1);
  localparam int unsigned EW = (CW > 7) ? CW : 7;
  localparam int unsigned NW = $clog2(MAX_ID + 2);
  localparam int unsigned GW = (NW > 8) ? NW : 8;
  localparam logic [CW-1:0] DepthC   = CW'(FREE_DEPTH);
  localparam logic [NW-1:0] MaxIdN   = NW'(MAX_ID);
  localparam logic [NW-1:0] FirstIdN = NW'(FirstId);
  localparam logic [7:0]    MaxIdLow = 8'(MAX_ID);

  logic [7:0]    mem_q [FREE_DEPTH];
  logic [7:0]    rd_q;
  logic [NW-1:0] fresh_q, fresh_d;
  logic [CW-1:0] top_q, top_d;
  logic [15:0]   live_q, live_d;
  logic [15:0]   peak_q, peak_d;
  logic [15:0]   exh_q, exh_d;
  via_rsp_t      rsp_q;

  logic          is_alloc, is_rel, stack_hit, fresh_ok, rel_ok, push_ok;
  logic [7:0]    grant;
  logic          fallback;
  logic [AW-1:0] pop_addr, push_addr;
  logic [GW-1:0] fresh_ext;
  logic [EW-1:0] top_ext;
  logic [16:0]   rid_w;

  assign is_alloc  = (req_i.req_type == ReqAlloc);
  assign is_rel    = (req_i.req_type == ReqRelease) && (req_i.release_id != 8'd0);
  assign stack_hit = (top_q != '0);
  assign fresh_ok  = (fresh_q <= MaxIdN);
  assign rid_w     = 17'(req_i.release_id);
  assign rel_ok    = (rid_w >= 17'(FirstId)) && (rid_w <= 17'(MAX_ID));
  assign push_ok   = is_rel && rel_ok && (top_q < DepthC);
  assign pop_addr  = AW'(top_q - CW'(1));
  assign push_addr = AW'(top_q);
  assign fresh_ext = GW'(fresh_q);

  assign sts_o.pop_hit = is_alloc && stack_hit;

  always_comb begin
    fresh_d  = fresh_q;
    top_d    = top_q;
    live_d   = live_q;
    peak_d   = peak_q;
    exh_d    = exh_q;
    grant    = 8'd0;
    fallback = 1'b0;
    unique case (req_i.req_type)
      ReqAlloc: begin
        if (stack_hit) begin
          top_d = top_q - CW'(1);
        end else if (fresh_ok) begin
          grant   = fresh_ext[7:0];
          fresh_d = fresh_q + NW'(1);
        end else begin
          grant    = MaxIdLow;
          fallback = 1'b1;
          if (exh_q != SatMax) begin
            exh_d = exh_q + 16'd1;
          end
        end
        if (live_q != SatMax) begin
          live_d = live_q + 16'd1;
        end
        if (live_d > peak_q) begin
          peak_d = live_d;
        end
      end
      ReqRelease: begin
        if (is_rel) begin
          if (live_q != 16'd0) begin
            live_d = live_q - 16'd1;
          end
          if (push_ok) begin
            top_d = top_q + CW'(1);
          end
        end
      end
      ReqReset: begin
        fresh_d = FirstIdN;
        top_d   = '0;
        live_d  = '0;
        peak_d  = '0;
        exh_d   = '0;
      end
      default: begin
        fresh_d = fresh_q;
      end
    endcase
  end

  assign top_ext = EW'(top_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= FirstIdN;
      top_q   <= '0;
      live_q  <= '0;
      peak_q  <= '0;
      exh_q   <= '0;
    end else if (cmd_i.exec) begin
      fresh_q <= fresh_d;
      top_q   <= top_d;
      live_q  <= live_d;
      peak_q  <= peak_d;
      exh_q   <= exh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push_ok) begin
      mem_q[push_addr] <= req_i.release_id;
    end
    if (cmd_i.exec && sts_o.pop_hit) begin
      rd_q <= mem_q[pop_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rsp_q.granted_id    <= grant;
      rsp_q.used_fallback <= fallback;
      rsp_q.live_now      <= live_d;
      rsp_q.live_peak     <= peak_d;
      rsp_q.exhaust_total <= exh_d;
      rsp_q.free_entries  <= top_ext[6:0];
    end else if (cmd_i.load_pop) begin
      rsp_q.granted_id <= rd_q;
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

// ===== src/view_id_allocator.sv =====
// Top level of the view id allocator: LIFO free stack with bump allocation.
// Instantiates via_ctrl and via_dpath; depends on via_pkg.
//
//   port group   direction  handshake               payload
//   in_*         input      in_valid_i/in_ready_o   via_req_t  (req_type, release_id)
//   out_*        output     out_valid_o/out_ready_i via_rsp_t  (granted_id .. free_entries)
//
// The result is valid the cycle after the accepting edge; when an allocate pops
// the free stack, the StPop state comes first (one registered memory read).
// One transaction is in flight at a time; in_ready_o returns the cycle after
// the result is taken, so no new request is accepted until then.
// Reset empties the stack and clears the counters at once; no clearing pass.
// A stalled result holds in the output register until out_ready_i.
`timescale 1ns / 1ps
`default_nettype none

module view_id_allocator #(
  parameter int unsigned MAX_ID     = 255,
  parameter int unsigned FREE_DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire via_pkg::via_req_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output via_pkg::via_rsp_t      out_data_o
);
  import via_pkg::*;

  via_cmd_t cmd;
  via_sts_t sts;

  via_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  via_dpath #(
    .MAX_ID     (MAX_ID),
    .FREE_DEPTH (FREE_DEPTH)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_data_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (out_data_o)
  );

endmodule

`default_nettype wire
